### design/ima_adpcm_block_decoder_defines.svh
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder: assertion macros
// Shared property wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef IMA_ADPCM_BLOCK_DECODER_DEFINES_SVH
`define IMA_ADPCM_BLOCK_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IAB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IAB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/iab_pkg.sv
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder: package
// Shared types, constants and the step table.
// ----------------------------------------------------------------------------
package iab_pkg;

  localparam int unsigned MaxChannelsDef = 2;
  localparam int unsigned QueueDepthDef  = 4;
  localparam int unsigned StepMax        = 88;
  localparam int unsigned ChunkSlots     = 16;  // samples per bank
  localparam int unsigned MemAddrW       = 5;   // bank bit + slot

  typedef enum logic {
    REG_CHANNEL_COUNT = 1'b0,
    REG_BLOCK_BYTES   = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_PRED = 2'd0,
    CMD_STEP = 2'd1,
    CMD_BAD  = 2'd2,
    CMD_DATA = 2'd3
  } cmd_kind_e;

  // front -> back command word
  typedef struct packed {
    cmd_kind_e   kind;
    logic        ch;
    logic        stereo;
    logic [1:0]  slot;   // byte within the channel's 4-byte chunk
    logic        flush;  // last byte of the chunk
    logic [15:0] data;
  } cmd_t;

  // decoder -> emitter job
  typedef struct packed {
    logic        dump;   // 1: dump a sample bank, 0: single sample
    logic        bank;
    logic        stereo;
    logic        ch;
    logic        hdr;
    logic        bad;
    logic [15:0] pcm;
  } job_t;

  // decoder -> sample bank write port
  typedef struct packed {
    logic                en;
    logic [MemAddrW-1:0] addr;
    logic [15:0]         data;
  } mem_wr_t;

  localparam logic [15:0] StepTable [89] = '{
    16'd7,     16'd8,     16'd9,     16'd10,    16'd11,    16'd12,    16'd13,    16'd14,
    16'd16,    16'd17,    16'd19,    16'd21,    16'd23,    16'd25,    16'd28,    16'd31,
    16'd34,    16'd37,    16'd41,    16'd45,    16'd50,    16'd55,    16'd60,    16'd66,
    16'd73,    16'd80,    16'd88,    16'd97,    16'd107,   16'd118,   16'd130,   16'd143,
    16'd157,   16'd173,   16'd190,   16'd209,   16'd230,   16'd253,   16'd279,   16'd307,
    16'd337,   16'd371,   16'd408,   16'd449,   16'd494,   16'd544,   16'd598,   16'd658,
    16'd724,   16'd796,   16'd876,   16'd963,   16'd1060,  16'd1166,  16'd1282,  16'd1411,
    16'd1552,  16'd1707,  16'd1878,  16'd2066,  16'd2272,  16'd2499,  16'd2749,  16'd3024,
    16'd3327,  16'd3660,  16'd4026,  16'd4428,  16'd4871,  16'd5358,  16'd5894,  16'd6484,
    16'd7132,  16'd7845,  16'd8630,  16'd9493,  16'd10442, 16'd11487, 16'd12635, 16'd13899,
    16'd15289, 16'd16818, 16'd18500, 16'd20350, 16'd22385, 16'd24623, 16'd27086, 16'd29794,
    16'd32767
  };

  // index table: -1 for small codes, 2/4/6/8 for large ones
  function automatic logic signed [4:0] index_adjust(input logic [2:0] code);
    logic signed [4:0] adj;
    if (code[2]) begin
      adj = signed'({2'b00, code[1:0], 1'b0}) + 5'sd2;
    end else begin
      adj = -5'sd1;
    end
    return adj;
  endfunction

endpackage

### design/iab_front.sv
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder: front end
// Tracks block position, parses channel headers and issues commands.
// ----------------------------------------------------------------------------
module iab_front import iab_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  data_byte_i,
  output logic        in_stall_o,
  input  logic [1:0]  channel_count_i,
  input  logic [15:0] block_bytes_i,
  input  logic        full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [15:0] pos_q, pos_d;
  logic        skip_q, skip_d;
  logic [7:0]  hold_q, hold_d;

  logic        acc, cfg_ok, stereo;
  logic [15:0] hdr_len, d, dq, chunks;
  logic [16:0] pos_inc;
  logic [2:0]  r;

  assign in_stall_o = full_i;
  assign acc        = in_valid_i && !full_i;
  assign cfg_ok     = (channel_count_i != 2'd0) && (32'(channel_count_i) <= MAX_CHANNELS)
                      && (block_bytes_i != 16'd0);
  assign stereo     = (channel_count_i == 2'd2);
  assign hdr_len    = stereo ? 16'd8 : 16'd4;
  assign d          = pos_q - hdr_len;
  assign dq         = stereo ? (d >> 3) : (d >> 2);
  assign chunks     = stereo ? ((block_bytes_i - hdr_len) >> 3)
                             : ((block_bytes_i - hdr_len) >> 2);
  assign r          = stereo ? d[2:0] : {1'b0, d[1:0]};
  assign pos_inc    = {1'b0, pos_q} + 17'd1;

  always_comb begin
    pos_d        = pos_q;
    skip_d       = skip_q;
    hold_d       = hold_q;
    push_o       = 1'b0;
    cmd_o.kind   = CMD_DATA;
    cmd_o.ch     = 1'b0;
    cmd_o.stereo = stereo;
    cmd_o.slot   = 2'd0;
    cmd_o.flush  = 1'b0;
    cmd_o.data   = 16'd0;
    if (acc && cfg_ok) begin
      if (!skip_q && (block_bytes_i >= hdr_len)) begin
        if (pos_q < hdr_len) begin
          cmd_o.ch = pos_q[2];
          case (pos_q[1:0])
            2'd0: begin
              hold_d = data_byte_i;
            end
            2'd1: begin
              push_o     = 1'b1;
              cmd_o.kind = CMD_PRED;
              cmd_o.data = {data_byte_i, hold_q};
            end
            2'd2: begin
              push_o = 1'b1;
              if (data_byte_i > 8'(StepMax)) begin
                cmd_o.kind = CMD_BAD;
                skip_d     = 1'b1;
              end else begin
                cmd_o.kind = CMD_STEP;
                cmd_o.data = {8'h00, data_byte_i};
              end
            end
            default: begin
              if (data_byte_i != 8'h00) begin
                push_o     = 1'b1;
                cmd_o.kind = CMD_BAD;
                skip_d     = 1'b1;
              end
            end
          endcase
        end else if (dq < chunks) begin
          push_o      = 1'b1;
          cmd_o.kind  = CMD_DATA;
          cmd_o.ch    = r[2];
          cmd_o.slot  = r[1:0];
          cmd_o.flush = (r == (stereo ? 3'd7 : 3'd3));
          cmd_o.data  = {8'h00, data_byte_i};
        end
      end
      // end of block: wrap and drop the skip flag
      if (pos_inc >= {1'b0, block_bytes_i}) begin
        pos_d  = 16'd0;
        skip_d = 1'b0;
      end else begin
        pos_d = pos_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 16'd0;
      skip_q <= 1'b0;
      hold_q <= 8'd0;
    end else begin
      pos_q  <= pos_d;
      skip_q <= skip_d;
      hold_q <= hold_d;
    end
  end

endmodule

### design/iab_queue.sv
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder: command queue
// Small FIFO between front end and decoder.
// ----------------------------------------------------------------------------
module iab_queue import iab_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            slots_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### design/iab_decode.sv
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder: nibble decoder
// Per-channel predictor and step index; one nibble per cycle unless stalled.
// ----------------------------------------------------------------------------
module iab_decode import iab_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    job_valid_o,
  output job_t    job_o,
  input  logic    job_ready_i,
  output mem_wr_t wr_o
);

  localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [15:0] pred_q [MAX_CHANNELS];
  logic [6:0]  sidx_q [MAX_CHANNELS];
  logic        phase_q;   // 0 low nibble, 1 high nibble
  logic        bank_q;    // bank being filled

  logic [ChW-1:0]     ch;
  logic [3:0]         code;
  logic [6:0]         cur_idx;
  logic [15:0]        step;
  logic [16:0]        delta;
  logic signed [17:0] p_ext, p_sum;
  logic [15:0]        p_sat;
  logic signed [7:0]  ni;
  logic [6:0]         ni_clamp;
  logic [2:0]         slot3;
  logic [3:0]         addr4;
  logic               nib_go;

  assign ch      = (MAX_CHANNELS > 1) ? ChW'(cmd_i.ch) : '0;
  assign code    = phase_q ? cmd_i.data[7:4] : cmd_i.data[3:0];
  assign cur_idx = (sidx_q[ch] > 7'(StepMax)) ? 7'(StepMax) : sidx_q[ch];
  assign step    = StepTable[cur_idx];

  always_comb begin
    delta = {4'd0, step[15:3]};
    if (code[0]) delta = delta + {3'd0, step[15:2]};
    if (code[1]) delta = delta + {2'd0, step[15:1]};
    if (code[2]) delta = delta + {1'b0, step};
  end

  assign p_ext = signed'({{2{pred_q[ch][15]}}, pred_q[ch]});
  assign p_sum = code[3] ? (p_ext - signed'({1'b0, delta})) : (p_ext + signed'({1'b0, delta}));

  always_comb begin
    if (p_sum < -18'sd32768) begin
      p_sat = 16'h8000;
    end else if (p_sum > 18'sd32767) begin
      p_sat = 16'h7FFF;
    end else begin
      p_sat = p_sum[15:0];
    end
  end

  assign ni = signed'({1'b0, cur_idx}) + 8'(index_adjust(code[2:0]));

  always_comb begin
    if (ni < 8'sd0) begin
      ni_clamp = 7'd0;
    end else if (ni > 8'(StepMax)) begin
      ni_clamp = 7'(StepMax);
    end else begin
      ni_clamp = ni[6:0];
    end
  end

  // sample slot i*2+phase; stereo interleaves channels
  assign slot3 = {cmd_i.slot, phase_q};
  assign addr4 = cmd_i.stereo ? {slot3, cmd_i.ch} : {1'b0, slot3};

  always_comb begin
    job_o.dump   = (cmd_i.kind == CMD_DATA);
    job_o.bank   = bank_q;
    job_o.stereo = cmd_i.stereo;
    job_o.ch     = cmd_i.ch;
    job_o.hdr    = (cmd_i.kind == CMD_PRED);
    job_o.bad    = (cmd_i.kind == CMD_BAD);
    job_o.pcm    = (cmd_i.kind == CMD_PRED) ? cmd_i.data : 16'd0;
    job_valid_o  = 1'b0;
    cmd_pop_o    = 1'b0;
    nib_go       = 1'b0;
    if (cmd_valid_i) begin
      case (cmd_i.kind)
        CMD_PRED, CMD_BAD: begin
          job_valid_o = 1'b1;
          cmd_pop_o   = job_ready_i;
        end
        CMD_STEP: begin
          cmd_pop_o = 1'b1;
        end
        CMD_DATA: begin
          if (!phase_q) begin
            nib_go = 1'b1;
          end else if (cmd_i.flush) begin
            // last nibble of chunk waits for the emitter to take the bank
            job_valid_o = 1'b1;
            nib_go      = job_ready_i;
            cmd_pop_o   = job_ready_i;
          end else begin
            nib_go    = 1'b1;
            cmd_pop_o = 1'b1;
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
    wr_o.en   = nib_go;
    wr_o.addr = {bank_q, addr4};
    wr_o.data = p_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        pred_q[k] <= 16'd0;
        sidx_q[k] <= 7'd0;
      end
      phase_q <= 1'b0;
      bank_q  <= 1'b0;
    end else begin
      if (cmd_valid_i && cmd_pop_o && (cmd_i.kind == CMD_PRED)) begin
        pred_q[ch] <= cmd_i.data;
      end
      if (cmd_valid_i && (cmd_i.kind == CMD_STEP)) begin
        sidx_q[ch] <= cmd_i.data[6:0];
      end
      if (nib_go) begin
        pred_q[ch] <= p_sat;
        sidx_q[ch] <= ni_clamp;
        phase_q    <= !phase_q;
      end
      if (nib_go && phase_q && cmd_i.flush) begin
        bank_q <= !bank_q;
      end
    end
  end

endmodule

### design/iab_emit.sv
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder: sample emitter
// Two sample banks and output register; one sample per cycle unless stalled.
// ----------------------------------------------------------------------------
module iab_emit import iab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mem_wr_t            wr_i,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               job_ready_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pcm_sample_o,
  output logic               channel_id_o,
  output logic               is_header_o,
  output logic               bad_block_o,
  output logic               last_of_run_o
);

  localparam int unsigned IdxW = $clog2(ChunkSlots);

  logic [15:0] mem_q [2*ChunkSlots];

  logic            busy_q;
  job_t            job_q;
  logic [IdxW-1:0] idx_q, last_idx;
  logic            out_valid_q;
  logic [15:0]     out_pcm_q;
  logic            out_ch_q, out_hdr_q, out_bad_q, out_last_q;
  logic            out_free, fin, load, take;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign last_idx    = job_q.stereo ? IdxW'(ChunkSlots - 1) : IdxW'(ChunkSlots / 2 - 1);
  assign fin         = job_q.dump ? (idx_q == last_idx) : 1'b1;
  assign load        = busy_q && out_free;
  assign job_ready_o = !busy_q || (load && fin);
  assign take        = job_valid_i && job_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (load) begin
        if (fin) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      job_q <= job_i;
    end
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (load) begin
      if (job_q.dump) begin
        out_pcm_q  <= mem_q[{job_q.bank, idx_q}];
        out_ch_q   <= job_q.stereo & idx_q[0];
        out_hdr_q  <= 1'b0;
        out_bad_q  <= 1'b0;
        out_last_q <= fin;
      end else begin
        out_pcm_q  <= job_q.pcm;
        out_ch_q   <= job_q.ch;
        out_hdr_q  <= job_q.hdr;
        out_bad_q  <= job_q.bad;
        out_last_q <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pcm_sample_o  = signed'(out_pcm_q);
  assign channel_id_o  = out_ch_q;
  assign is_header_o   = out_hdr_q;
  assign bad_block_o   = out_bad_q;
  assign last_of_run_o = out_last_q;

endmodule

### design/ima_adpcm_block_decoder.sv
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder
// WAV IMA ADPCM 4-bit byte stream in, tagged 16-bit PCM samples out.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   in      | sink      | in_valid_i/in_stall_o  | data_byte_i
//   out     | source    | out_valid_o/out_stall_i| pcm_sample_o, channel_id_o,
//           |           |                        | is_header_o, bad_block_o,
//           |           |                        | last_of_run_o
//   cfg     | sink      | cfg_we_i (no wait)     | cfg_index_i, cfg_data_i
//
// Flow: the front end takes one byte per cycle into a command queue while
// it is not full. The decoder works one nibble per cycle unless a chunk's
// last nibble waits for the emitter; the serial predictor update of each
// data byte's two nibbles sets the sustained rate. Unless out_stall_i holds
// them, samples leave one per cycle from the bank the decoder is not filling.
// Reset: asynchronous, active low; registers read channel_count 1 and
// block_bytes 1024, position, skip flag and channel state start at zero.
// Stalls: out_stall_i holds the output register and backs up through the
// emitter, decoder and queue to in_stall_o (queue full).
// ----------------------------------------------------------------------------
module ima_adpcm_block_decoder import iab_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef,
  parameter int unsigned QUEUE_DEPTH  = QueueDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte stream
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  // samples
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] pcm_sample_o,
  output logic               channel_id_o,
  output logic               is_header_o,
  output logic               bad_block_o,
  output logic               last_of_run_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // config registers; new values act at once, position is kept
  logic [1:0]  chan_cnt_q;
  logic [15:0] blk_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q  <= 2'd1;
      blk_bytes_q <= 16'd1024;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_CHANNEL_COUNT: chan_cnt_q  <= cfg_data_i[1:0];
        REG_BLOCK_BYTES:   blk_bytes_q <= cfg_data_i;
        default:           chan_cnt_q  <= chan_cnt_q;
      endcase
    end
  end

  // front end -> queue
  logic q_full, q_push;
  cmd_t f_cmd;

  iab_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .data_byte_i     (data_byte_i),
    .in_stall_o      (in_stall_o),
    .channel_count_i (chan_cnt_q),
    .block_bytes_i   (blk_bytes_q),
    .full_i          (q_full),
    .push_o          (q_push),
    .cmd_o           (f_cmd)
  );

  // queue -> decoder
  logic q_valid, q_pop;
  cmd_t q_cmd;

  iab_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // decoder -> emitter: jobs plus bank writes
  logic    job_valid, job_ready;
  job_t    job;
  mem_wr_t bank_wr;

  iab_decode #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready),
    .wr_o        (bank_wr)
  );

  iab_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .wr_i          (bank_wr),
    .job_valid_i   (job_valid),
    .job_i         (job),
    .job_ready_o   (job_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pcm_sample_o  (pcm_sample_o),
    .channel_id_o  (channel_id_o),
    .is_header_o   (is_header_o),
    .bad_block_o   (bad_block_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### design/iab_checker.sv
// ----------------------------------------------------------------------------
// IMA ADPCM block decoder: port checker
// Output-side properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "ima_adpcm_block_decoder_defines.svh"

module iab_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] pcm_sample_o,
  input logic               channel_id_o,
  input logic               is_header_o,
  input logic               bad_block_o,
  input logic               last_of_run_o
);

  // bad header word carries zero and ends its run
  `IAB_ASSERT_IMP(a_bad_word, clk_i, rst_ni, out_valid_o && bad_block_o, pcm_sample_o == 16'sd0 && !is_header_o && last_of_run_o, "bad block word malformed")

  // header predictor word is alone in its run and not flagged bad
  `IAB_ASSERT_IMP(a_hdr_alone, clk_i, rst_ni, out_valid_o && is_header_o, last_of_run_o && !bad_block_o, "header word not alone")

  // stalled word holds
  `IAB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(pcm_sample_o) && $stable(channel_id_o) && $stable(last_of_run_o), "stalled word changed")

endmodule

bind ima_adpcm_block_decoder iab_checker u_iab_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pcm_sample_o  (pcm_sample_o),
  .channel_id_o  (channel_id_o),
  .is_header_o   (is_header_o),
  .bad_block_o   (bad_block_o),
  .last_of_run_o (last_of_run_o)
);
